// ===== design/control_flow_edge_learn_and_check_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the control-flow edge learner and checker
// Clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef CONTROL_FLOW_EDGE_LEARN_AND_CHECK_MACROS_SVH
`define CONTROL_FLOW_EDGE_LEARN_AND_CHECK_MACROS_SVH

// Same-cycle implication.
`define CFELC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cfelc assertion failed");

// Next-cycle implication.
`define CFELC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cfelc assertion failed");

`endif

// ===== design/cfelc_pkg.sv =====
// ----------------------------------------------------------------------------
// cfelc_pkg
// Shared types and constants of the control-flow edge learner and checker.
// ----------------------------------------------------------------------------
package cfelc_pkg;

  localparam int EDGE_SLOTS = 1024;
  localparam int CNT_W      = $clog2(EDGE_SLOTS + 1);
  localparam int GROUP      = 32;
  localparam int NUM_GROUPS = (EDGE_SLOTS + GROUP - 1) / GROUP;
  localparam int ID_W       = 64;

  typedef struct packed {
    logic [ID_W-1:0] src;
    logic [ID_W-1:0] tgt;
  } edge_t;

  // control from the sequencer to the edge row
  typedef struct packed {
    logic             shift;
    logic [CNT_W-1:0] fill;
    edge_t            query;
  } row_ctrl_t;

endpackage

// ===== design/control_flow_edge_learn_and_check.sv =====
// ----------------------------------------------------------------------------
// control_flow_edge_learn_and_check
// Learns control-flow edges from id streams, then checks paths against them.
// The result strobe follows the accept through compare, group reduce and
// decide into the output register. No new item is taken until the last one
// is through: busy holds through compare, reduce and decide.
// Reset (rst, synchronous): registers to defaults, learning phase, edge row
// empty (fill count 0, no clearing pass). Results cannot be stalled.
// ----------------------------------------------------------------------------
`include "control_flow_edge_learn_and_check_macros.svh"

module control_flow_edge_learn_and_check (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] id_value,
  output logic        done,
  output logic        verify_mode,
  output logic        used,
  output logic        violation,
  output logic        path_done,
  output logic        request_bad,
  output logic        store_full,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import cfelc_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_RED  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  localparam logic [1:0] REG_START = 2'd0;
  localparam logic [1:0] REG_END   = 2'd1;
  localparam logic [1:0] REG_LEARN = 2'd2;

  localparam logic [31:0] CNT_MAX = '1;

  logic [1:0]        state;
  logic [63:0]       start_code;
  logic [63:0]       end_code;
  logic [31:0]       learning_requests;
  logic [63:0]       id_reg;
  logic              in_verify, in_verify_next;
  logic              path_active, path_active_next;
  logic [31:0]       paths_learned, paths_learned_next;
  logic [63:0]       position_id, position_id_next;
  logic              bad_flag, bad_flag_next;
  logic [CNT_W-1:0]  edge_count;
  logic              insert;
  logic              used_next, viol_next, pdone_next, full_next;
  logic              found;
  logic              cfg_wr;
  row_ctrl_t         row_ctrl;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_code        <= 64'd1;
      end_code          <= 64'd2;
      learning_requests <= 32'd16;
    end else if (cfg_wr) begin
      unique case (paddr[4:3])
        REG_START: start_code        <= pwdata;
        REG_END:   end_code          <= pwdata;
        REG_LEARN: learning_requests <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      REG_START: prdata = start_code;
      REG_END:   prdata = end_code;
      REG_LEARN: prdata = {32'd0, learning_requests};
      default:   prdata = '0;
    endcase
  end

  // edge row
  assign row_ctrl.shift     = insert;
  assign row_ctrl.fill      = edge_count;
  assign row_ctrl.query.src = position_id;
  assign row_ctrl.query.tgt = id_reg;

  cfelc_row u_row (
    .clk   (clk),
    .ctrl  (row_ctrl),
    .found (found)
  );

  assign busy = (state != S_IDLE);

  // path decision, evaluated in the final cycle
  always_comb begin
    in_verify_next     = in_verify;
    path_active_next   = path_active;
    paths_learned_next = paths_learned;
    position_id_next   = position_id;
    bad_flag_next      = bad_flag;
    insert             = 1'b0;
    used_next          = 1'b0;
    viol_next          = 1'b0;
    pdone_next         = 1'b0;
    full_next          = 1'b0;
    if (state == S_FIN && id_reg != 64'd0) begin
      if (!in_verify) begin
        if (id_reg == start_code) begin
          if (paths_learned >= learning_requests) begin
            in_verify_next = 1'b1;
            bad_flag_next  = 1'b0;
          end else if (paths_learned != CNT_MAX) begin
            paths_learned_next = paths_learned + 32'd1;
          end
          path_active_next = 1'b1;
          position_id_next = start_code;
          used_next        = 1'b1;
        end else if (path_active) begin
          used_next = 1'b1;
          if (id_reg == end_code) begin
            path_active_next = 1'b0;
            pdone_next       = 1'b1;
          end
          if (!found) begin
            if (edge_count < CNT_W'(EDGE_SLOTS)) begin
              insert = 1'b1;
            end else begin
              full_next = 1'b1;
            end
          end
          position_id_next = id_reg;
        end
      end else begin
        if (path_active) begin
          used_next = 1'b1;
          if (id_reg == end_code) begin
            path_active_next = 1'b0;
            pdone_next       = 1'b1;
          end
          if (found) begin
            position_id_next = id_reg;
          end else begin
            viol_next     = 1'b1;
            bad_flag_next = 1'b1;
          end
        end else if (id_reg == start_code) begin
          bad_flag_next    = 1'b0;
          position_id_next = start_code;
          path_active_next = 1'b1;
          used_next        = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      in_verify     <= 1'b0;
      path_active   <= 1'b0;
      paths_learned <= '0;
      position_id   <= '0;
      bad_flag      <= 1'b0;
      edge_count    <= '0;
      done          <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: if (start) begin
          state <= S_CMP;
        end
        S_CMP: state <= S_RED;
        S_RED: state <= S_FIN;
        S_FIN: begin
          state         <= S_IDLE;
          done          <= 1'b1;
          in_verify     <= in_verify_next;
          path_active   <= path_active_next;
          paths_learned <= paths_learned_next;
          position_id   <= position_id_next;
          bad_flag      <= bad_flag_next;
          if (insert) begin
            edge_count <= edge_count + CNT_W'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      id_reg <= id_value;
    end
    if (state == S_FIN) begin
      verify_mode <= in_verify_next;
      used        <= used_next;
      violation   <= viol_next;
      path_done   <= pdone_next;
      request_bad <= bad_flag_next;
      store_full  <= full_next;
    end
  end

  `CFELC_ASSERT_NEXT(a_done_after_fin, state == S_FIN, done)
  `CFELC_ASSERT_NOW(a_fill_bound, 1'b1, edge_count <= CNT_W'(EDGE_SLOTS))
  `CFELC_ASSERT_NOW(a_full_only_when_full, done && store_full,
                    edge_count == CNT_W'(EDGE_SLOTS))
  `CFELC_ASSERT_NOW(a_viol_in_verify, done && violation, verify_mode && request_bad)
  `CFELC_ASSERT_NEXT(a_verify_sticky, in_verify, in_verify)

endmodule

// ===== design/cfelc_cell.sv =====
// ----------------------------------------------------------------------------
// cfelc_cell
// One edge slot: takes its left neighbor's edge on a shift and compares its
// content against the broadcast query every cycle.
// ----------------------------------------------------------------------------
module cfelc_cell (
  input  logic             clk,
  input  cfelc_pkg::edge_t edge_in,
  input  logic             shift,
  input  logic             live,
  input  cfelc_pkg::edge_t query,
  output cfelc_pkg::edge_t edge_out,
  output logic             hit
);
  import cfelc_pkg::*;

  edge_t slot;

  always_ff @(posedge clk) begin
    if (shift) begin
      slot <= edge_in;
    end
    hit <= live && (slot == query);
  end

  assign edge_out = slot;

endmodule

// ===== design/cfelc_row.sv =====
// ----------------------------------------------------------------------------
// cfelc_row
// Row of edge cells. New edges enter at cell 0 and push the rest along; the
// first fill cells hold live edges. Cell hits are reduced by a registered
// OR over groups of cells.
// ----------------------------------------------------------------------------
module cfelc_row (
  input  logic                 clk,
  input  cfelc_pkg::row_ctrl_t ctrl,
  output logic                 found
);
  import cfelc_pkg::*;

  localparam int PAD_W = NUM_GROUPS * GROUP;

  edge_t                  link [EDGE_SLOTS-1];
  logic [PAD_W-1:0]       hits;
  logic [NUM_GROUPS-1:0]  group_hit;

  genvar i;
  generate
    for (i = 0; i < EDGE_SLOTS; i++) begin : g_cell
      edge_t cell_in;
      if (i == 0) begin : g_head
        assign cell_in = ctrl.query;
      end else begin : g_body
        assign cell_in = link[i-1];
      end
      if (i < EDGE_SLOTS - 1) begin : g_link
        cfelc_cell u_cell (
          .clk      (clk),
          .edge_in  (cell_in),
          .shift    (ctrl.shift),
          .live     (CNT_W'(i) < ctrl.fill),
          .query    (ctrl.query),
          .edge_out (link[i]),
          .hit      (hits[i])
        );
      end else begin : g_tail
        cfelc_cell u_cell (
          .clk      (clk),
          .edge_in  (cell_in),
          .shift    (ctrl.shift),
          .live     (CNT_W'(i) < ctrl.fill),
          .query    (ctrl.query),
          .edge_out (),
          .hit      (hits[i])
        );
      end
    end
    if (PAD_W > EDGE_SLOTS) begin : g_pad
      assign hits[PAD_W-1:EDGE_SLOTS] = '0;
    end
  endgenerate

  always_ff @(posedge clk) begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      group_hit[g] <= |hits[g*GROUP +: GROUP];
    end
  end

  assign found = |group_hit;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Control-flow edge learner and checker testbench
// Drives id items through the command port and register writes through the
// APB port. A local copy of the edge store and path state predicts each result
// not fixed by a row of the short directed table, which comes first; then
// random paths built from a library of learned routes, mostly following it,
// with some broken on purpose. The run covers the learning phase, the edge
// store filling up, the switch to verification and several code settings.
// ----------------------------------------------------------------------------
module testbench;
  import cfelc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int POOL_SIZE   = 24;
  localparam int LIB_PATHS   = 8;
  localparam int MAX_HOPS    = 6;
  localparam int DIR_ROWS    = 17;

  typedef enum logic [1:0] {
    REG_START_CODE = 2'd0,
    REG_END_CODE   = 2'd1,
    REG_LEARN_REQS = 2'd2,
    REG_SPARE      = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic verify;
    logic used;
    logic viol;
    logic closed;
    logic bad;
    logic full;
  } flow_res_t;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic            fixed;
    flow_res_t       want;
  } dir_row_t;

  localparam flow_res_t R_IDLE   = 6'b000000;
  localparam flow_res_t R_TAKEN  = 6'b010000;
  localparam flow_res_t R_CLOSED = 6'b010100;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [63:0] id_value = '0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic        busy, done, verify_mode, used, violation, path_done;
  logic        request_bad, store_full, pready;
  logic [63:0] prdata;

  control_flow_edge_learn_and_check dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .id_value(id_value),
    .done(done), .verify_mode(verify_mode), .used(used), .violation(violation),
    .path_done(path_done), .request_bad(request_bad), .store_full(store_full),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // register copies
  logic [63:0] reg_start = 64'd1;
  logic [63:0] reg_end   = 64'd2;
  logic [31:0] reg_learn = 32'd16;

  // path state and edge store copies
  logic        cf_verify = 1'b0;
  logic        cf_active = 1'b0;
  logic [31:0] cf_paths  = '0;
  logic [63:0] cf_pos    = '0;
  logic        cf_bad    = 1'b0;
  logic [63:0] cf_src [EDGE_SLOTS];
  logic [63:0] cf_tgt [EDGE_SLOTS];
  int          cf_fill   = 0;

  flow_res_t   expected_q [$];
  int          mism_count = 0;
  int          items_sent = 0;
  int          burst_left = 0;
  bit          gaps_on = 1'b1;
  int          cycle_cnt = 0;

  logic [63:0] pool [POOL_SIZE];
  logic [63:0] lib_hops [LIB_PATHS][MAX_HOPS];
  int          lib_len [LIB_PATHS];

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{64'h0,                   1'b1, R_IDLE},
    '{64'h7,                   1'b1, R_IDLE},    // stray id, no path open
    '{64'h2,                   1'b1, R_IDLE},    // end code with no path
    '{64'h1,                   1'b1, R_TAKEN},
    '{64'h0,                   1'b1, R_IDLE},    // zero on an open path
    '{ALL_ONES,                1'b1, R_TAKEN},
    '{64'h8000_0000_0000_0000, 1'b0, R_IDLE},
    '{ALL_ONES,                1'b0, R_IDLE},
    '{64'h2,                   1'b1, R_CLOSED},
    '{64'h3,                   1'b1, R_IDLE},
    '{64'h1,                   1'b1, R_TAKEN},
    '{ALL_ONES,                1'b0, R_IDLE},    // edge already stored
    '{64'h1,                   1'b1, R_TAKEN},   // restart mid-path
    '{64'h5555_5555_5555_5555, 1'b0, R_IDLE},
    '{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, R_IDLE},
    '{64'h0000_0001_0000_0000, 1'b0, R_IDLE},
    '{64'h2,                   1'b1, R_CLOSED}
  };

  function automatic bit edge_seen(input logic [63:0] from_id, input logic [63:0] to_id);
    for (int i = 0; i < cf_fill; i++)
      if (cf_src[i] == from_id && cf_tgt[i] == to_id) return 1'b1;
    return 1'b0;
  endfunction

  function automatic flow_res_t step_flow(input logic [63:0] id);
    flow_res_t r;
    r = '0;
    if (id != '0) begin
      if (!cf_verify) begin
        if (id == reg_start) begin
          if (cf_paths >= reg_learn) begin
            cf_verify = 1'b1;
            cf_bad = 1'b0;
          end else if (cf_paths != 32'hFFFF_FFFF) begin
            cf_paths = cf_paths + 1;
          end
          cf_active = 1'b1;
          cf_pos = reg_start;
          r.used = 1'b1;
        end else if (cf_active) begin
          r.used = 1'b1;
          if (id == reg_end) begin
            cf_active = 1'b0;
            r.closed = 1'b1;
          end
          if (!edge_seen(cf_pos, id)) begin
            if (cf_fill < EDGE_SLOTS) begin
              cf_src[cf_fill] = cf_pos;
              cf_tgt[cf_fill] = id;
              cf_fill++;
            end else begin
              r.full = 1'b1;
            end
          end
          cf_pos = id;
        end
      end else if (cf_active) begin
        r.used = 1'b1;
        if (id == reg_end) begin
          cf_active = 1'b0;
          r.closed = 1'b1;
        end
        if (edge_seen(cf_pos, id)) begin
          cf_pos = id;
        end else begin
          r.viol = 1'b1;
          cf_bad = 1'b1;
        end
      end else if (id == reg_start) begin
        cf_bad = 1'b0;
        cf_pos = reg_start;
        cf_active = 1'b1;
        r.used = 1'b1;
      end
    end
    r.verify = cf_verify;
    r.bad = cf_bad;
    return r;
  endfunction

  task automatic send_item(input logic [63:0] v, input logic fixed, input flow_res_t want);
    flow_res_t pred;
    start <= 1'b1;
    id_value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    pred = step_flow(v);
    expected_q.push_back(fixed ? want : pred);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else if (gaps_on) begin
      // drop start for a random gap, then begin a new burst
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(0, 23);
    end
  endtask

  task automatic send_id(input logic [63:0] v);
    send_item(v, 1'b0, R_IDLE);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [63:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    // hold the port idle between writes
    @(posedge clk);
    case (idx)
      REG_START_CODE: reg_start = val;
      REG_END_CODE:   reg_end = val;
      REG_LEARN_REQS: reg_learn = val[31:0];
      default: ;
    endcase
  endtask

  // hold until every result is in, then let the pipeline drain
  task automatic settle();
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic send_path(input bit mutate);
    int p, k, kind;
    p = $urandom_range(0, LIB_PATHS - 1);
    k = $urandom_range(0, lib_len[p] - 1);
    kind = $urandom_range(0, 4);
    send_id(reg_start);
    for (int i = 0; i < lib_len[p]; i++) begin
      if (mutate && i == k) begin
        if (kind == 1) send_id(pool[$urandom_range(0, POOL_SIZE - 1)]);
        else if (kind == 2) send_id(reg_start);
        else if (kind == 3) send_id('0);
      end
      // kind 0 drops the hop, kind 1 replaces it
      if (!(mutate && i == k && kind <= 1)) send_id(lib_hops[p][i]);
    end
    if (!(mutate && kind == 4)) send_id(reg_end);
  endtask

  task automatic run_traffic(input int n);
    int target, r;
    target = items_sent + n;
    while (items_sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 70) send_path($urandom_range(0, 5) == 0);
      else if (r < 80) send_id(pool[$urandom_range(0, POOL_SIZE - 1)]);
      else if (r < 86) send_id('0);
      else if (r < 93) send_id(reg_start);
      else send_id({$urandom, $urandom});
    end
  endtask

  always @(posedge clk) begin : result_check
    flow_res_t got, want;
    if (!rst && done) begin
      got = {verify_mode, used, violation, path_done, request_bad, store_full};
      if (expected_q.size() == 0) begin
        if (mism_count < 10) $display("result with no item pending at cycle %0d", cycle_cnt);
        mism_count++;
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          if (mism_count < 10)
            $display({"mismatch at cycle %0d (exp/act): verify_mode %b/%b used %b/%b ",
                      "%s%b/%b %s%b/%b %s%b/%b %s%b/%b"},
                     cycle_cnt, want.verify, got.verify, want.used, got.used,
                     "violation ", want.viol, got.viol, "path_done ", want.closed, got.closed,
                     "request_bad ", want.bad, got.bad, "store_full ", want.full, got.full);
          mism_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    logic [63:0] s1, e1, s2;
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool[i] = {$urandom, $urandom};
      if (pool[i] == '0) pool[i] = 64'h3;
    end
    for (int p = 0; p < LIB_PATHS; p++) begin
      lib_len[p] = $urandom_range(1, MAX_HOPS);
      for (int i = 0; i < MAX_HOPS; i++) lib_hops[p][i] = pool[$urandom_range(0, POOL_SIZE - 1)];
    end
    s1 = {$urandom, $urandom} | 64'h1;
    e1 = {$urandom, $urandom};
    if (e1 == s1 || e1 == '0) e1 = s1 ^ 64'h8000_0000_0000_0002;
    s2 = {$urandom, $urandom};
    if (s2 == s1 || s2 == e1 || s2 == '0) s2 = s1 ^ 64'h4;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++)
      send_item(dir_rows[i].id, dir_rows[i].fixed, dir_rows[i].want);
    settle();

    // start equal to end, both at the top of the range
    cfg_write(REG_START_CODE, ALL_ONES);
    cfg_write(REG_END_CODE, ALL_ONES);
    cfg_write(REG_LEARN_REQS, 64'hFFFF_FFFF);
    cfg_write(REG_SPARE, {$urandom, $urandom});
    run_traffic(30);
    settle();

    // a zero start code never opens a path
    cfg_write(REG_START_CODE, '0);
    run_traffic(12);
    settle();

    // learn the route library
    cfg_write(REG_START_CODE, s1);
    cfg_write(REG_END_CODE, e1);
    run_traffic(80);

    // overrun the edge store with one long path of fresh ids
    send_id(reg_start);
    gaps_on = 1'b0;
    repeat (200) send_id({$urandom, $urandom});
    gaps_on = 1'b1;
    while (cf_fill < EDGE_SLOTS) send_id({$urandom, $urandom});
    repeat (24) send_id({$urandom, $urandom});
    send_id(reg_end);
    settle();

    // a few more learned paths, then verification takes over
    cfg_write(REG_LEARN_REQS, {32'h0, cf_paths + 32'd4});
    run_traffic(80);
    settle();

    // root id changed after learning
    cfg_write(REG_LEARN_REQS, '0);
    cfg_write(REG_START_CODE, s2);
    run_traffic(30);
    settle();

    cfg_write(REG_START_CODE, e1);
    run_traffic(30);
    settle();

    cfg_write(REG_START_CODE, s1);
    run_traffic(60);
    settle();

    if (mism_count == 0 && expected_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
